// ===== hdl/esau_pkg.sv =====
// Package for the encoder speed and angle unit: register map, reset values
// and field widths. Used by encoder_speed_angle_unit; depends on nothing.
package esau_pkg;

   localparam int WINDOW_DEFAULT = 10;

   localparam int COUNT_W  = 16;
   localparam int DELTA_W  = 17;
   localparam int SUM_W    = 20;
   localparam int ANGLE_W  = 16;
   localparam int CONV_W   = 24;
   localparam int MOD_W    = 17;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Register index, taken from paddr[4:2].
   typedef enum logic [2:0] {
      REG_CONV_FACTOR     = 3'd0,
      REG_COUNTS_PER_REV  = 3'd1,
      REG_ANGLE_OFFSET    = 3'd2,
      REG_FORCED_ANGLE    = 3'd3,
      REG_CALIBRATED      = 3'd4,
      REG_HALL_MODE       = 3'd5,
      REG_ENCODER_PRESENT = 3'd6
   } reg_index_type;

   localparam logic [CONV_W-1:0]  CONV_FACTOR_RST     = 24'd29360;
   localparam logic [MOD_W-1:0]   COUNTS_PER_REV_RST  = 17'd4000;
   localparam logic [ANGLE_W-1:0] ANGLE_OFFSET_RST    = 16'd0;
   localparam logic [ANGLE_W-1:0] FORCED_ANGLE_RST    = 16'd0;
   localparam logic               CALIBRATED_RST      = 1'b0;
   localparam logic               HALL_MODE_RST       = 1'b1;
   localparam logic               ENCODER_PRESENT_RST = 1'b0;

endpackage

// ===== hdl/encoder_speed_angle_unit.sv =====
// Encoder speed and electrical angle unit: top level with the APB-style
// register file, the input stage, the moving-sum datapath and the result stage.
// Depends on esau_pkg for the register map, reset values and widths.
//
// Feed sampled encoder counter values on the req_ channel. A transfer with
// req_type 0 is a capture tick: the change since the previous capture is
// formed, pulled back by counts_per_rev when it reaches half a revolution
// either way (counter wrap), stored in a ring of the last WINDOW changes, and
// the running sum of that ring is returned as rsp_speed_sum. A transfer with
// req_type 1 only reads the angle and leaves the speed state untouched. Every
// transfer returns exactly one result, in order: rsp_speed_sum (20 bit signed,
// wraps modulo 2^20) and rsp_elec_angle = (angle_offset + count*conv_factor)
// mod 65536, or forced_angle when encoder_present is 0 or when hall_mode is
// set and calibrated is still 0. Throughput is one item per clock while the
// result is taken; the transfer loads the input register, and when the result
// register is free or being emptied the item moves into it, with the whole
// wrap correction, ring update and 16x16 angle product done in the single
// step between the two registers. The ring read and write at ring_pos and the
// running-sum update happen in that step, so back-to-back captures see each
// other's state. The input register doubles as a skid stage, so a new item is
// taken while a finished result waits on rsp_ready, as long as the input
// register is free. Write registers only while the block is idle; reads are
// always allowed and pready is tied high.
module encoder_speed_angle_unit #(
   parameter int WINDOW = esau_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [esau_pkg::COUNT_W-1:0]         req_sample_count,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [esau_pkg::SUM_W-1:0]    rsp_speed_sum,
   output logic [esau_pkg::ANGLE_W-1:0]         rsp_elec_angle,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [esau_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [esau_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [esau_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [esau_pkg::CONV_W-1:0]  conv_factor_ff;
   logic [esau_pkg::MOD_W-1:0]   counts_per_rev_ff;
   logic [esau_pkg::ANGLE_W-1:0] angle_offset_ff;
   logic [esau_pkg::ANGLE_W-1:0] forced_angle_ff;
   logic                         calibrated_ff;
   logic                         hall_mode_ff;
   logic                         encoder_present_ff;

   logic                         csr_write;
   esau_pkg::reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = esau_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_factor_ff     <= esau_pkg::CONV_FACTOR_RST;
         counts_per_rev_ff  <= esau_pkg::COUNTS_PER_REV_RST;
         angle_offset_ff    <= esau_pkg::ANGLE_OFFSET_RST;
         forced_angle_ff    <= esau_pkg::FORCED_ANGLE_RST;
         calibrated_ff      <= esau_pkg::CALIBRATED_RST;
         hall_mode_ff       <= esau_pkg::HALL_MODE_RST;
         encoder_present_ff <= esau_pkg::ENCODER_PRESENT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            esau_pkg::REG_CONV_FACTOR:     conv_factor_ff     <= pwdata[23:0];
            esau_pkg::REG_COUNTS_PER_REV:  counts_per_rev_ff  <= pwdata[16:0];
            esau_pkg::REG_ANGLE_OFFSET:    angle_offset_ff    <= pwdata[15:0];
            esau_pkg::REG_FORCED_ANGLE:    forced_angle_ff    <= pwdata[15:0];
            esau_pkg::REG_CALIBRATED:      calibrated_ff      <= pwdata[0];
            esau_pkg::REG_HALL_MODE:       hall_mode_ff       <= pwdata[0];
            esau_pkg::REG_ENCODER_PRESENT: encoder_present_ff <= pwdata[0];
            default: begin
               // drop writes to unmapped addresses
            end
         endcase
      end
   end

   // Read back the selected register, zero-extended.
   always_comb begin
      unique case (csr_index)
         esau_pkg::REG_CONV_FACTOR:     prdata = {8'd0, conv_factor_ff};
         esau_pkg::REG_COUNTS_PER_REV:  prdata = {15'd0, counts_per_rev_ff};
         esau_pkg::REG_ANGLE_OFFSET:    prdata = {16'd0, angle_offset_ff};
         esau_pkg::REG_FORCED_ANGLE:    prdata = {16'd0, forced_angle_ff};
         esau_pkg::REG_CALIBRATED:      prdata = {31'd0, calibrated_ff};
         esau_pkg::REG_HALL_MODE:       prdata = {31'd0, hall_mode_ff};
         esau_pkg::REG_ENCODER_PRESENT: prdata = {31'd0, encoder_present_ff};
         default:                       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: input register (also the skid stage) and result register
   // ---------------------------------------------------------------------
   logic                          s1_valid_ff;
   logic                          s1_type_ff;
   logic [esau_pkg::COUNT_W-1:0]  s1_count_ff;
   logic                          rsp_valid_ff;
   logic                          advance;
   logic                          req_fire;

   // Move the held item into the result register when that register is free
   // or is being emptied in this cycle.
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff  <= req_type;
         s1_count_ff <= req_sample_count;
      end
   end

   // ---------------------------------------------------------------------
   // Speed datapath: wrap-corrected delta and moving sum over the ring
   // ---------------------------------------------------------------------
   logic [esau_pkg::COUNT_W-1:0]  prev_count_ff;
   logic [esau_pkg::DELTA_W-1:0]  ring_ff [WINDOW];
   logic [POS_W-1:0]              ring_pos_ff;
   logic [esau_pkg::SUM_W-1:0]    running_sum_ff;

   logic signed [18:0]            delta;
   logic signed [18:0]            modulus;
   logic signed [18:0]            half;
   logic signed [18:0]            corrected;
   logic [esau_pkg::DELTA_W-1:0]  stored;
   logic [esau_pkg::DELTA_W-1:0]  evicted;
   logic [esau_pkg::SUM_W-1:0]    sum_in;
   logic [POS_W-1:0]              ring_pos_in;
   logic                          capture;

   assign capture = advance & ~s1_type_ff;

   always_comb begin
      delta   = $signed({3'b000, s1_count_ff}) - $signed({3'b000, prev_count_ff});
      modulus = $signed({2'b00, counts_per_rev_ff});
      half    = $signed({3'b000, counts_per_rev_ff[16:1]});
      // Pull back a change of half a revolution or more by one revolution.
      priority if (delta >= half) begin
         corrected = delta - modulus;
      end else if (delta <= -half) begin
         corrected = delta + modulus;
      end else begin
         corrected = delta;
      end
      stored  = corrected[16:0];
      evicted = ring_ff[ring_pos_ff];
      sum_in  = running_sum_ff
              + {{(esau_pkg::SUM_W - esau_pkg::DELTA_W){stored[16]}}, stored}
              - {{(esau_pkg::SUM_W - esau_pkg::DELTA_W){evicted[16]}}, evicted};
      ring_pos_in = (ring_pos_ff == POS_LAST) ? '0 : ring_pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff  <= '0;
         ring_pos_ff    <= '0;
         running_sum_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (capture) begin
         prev_count_ff         <= s1_count_ff;
         ring_pos_ff           <= ring_pos_in;
         running_sum_ff        <= sum_in;
         ring_ff[ring_pos_ff]  <= stored;
      end
   end

   // ---------------------------------------------------------------------
   // Angle datapath: only the low 16 bits of the product matter
   // ---------------------------------------------------------------------
   logic [31:0]                   angle_product;
   logic [esau_pkg::ANGLE_W-1:0]  angle_scaled;
   logic [esau_pkg::ANGLE_W-1:0]  angle_sel;
   logic                          use_forced;

   always_comb begin
      angle_product = s1_count_ff * conv_factor_ff[15:0];
      angle_scaled  = angle_offset_ff + angle_product[15:0];
      use_forced    = ~encoder_present_ff | (hall_mode_ff & ~calibrated_ff);
      angle_sel     = use_forced ? forced_angle_ff : angle_scaled;
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic [esau_pkg::SUM_W-1:0]    rsp_sum_ff;
   logic [esau_pkg::ANGLE_W-1:0]  rsp_angle_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sum_ff   <= s1_type_ff ? running_sum_ff : sum_in;
         rsp_angle_ff <= angle_sel;
      end
   end

   assign rsp_speed_sum  = $signed(rsp_sum_ff);
   assign rsp_elec_angle = rsp_angle_ff;

`ifndef SYNTH
   // Ring pointer never leaves the window.
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      32'(ring_pos_ff) < WINDOW)
      else $error("ring pointer outside window");

   // An angle read leaves the speed state alone.
   a_read_keeps_sum: assert property (@(posedge clock) disable iff (reset)
      advance && s1_type_ff |=> $stable(running_sum_ff) && $stable(ring_pos_ff))
      else $error("angle read changed speed state");

   // A capture makes its count the new reference.
   a_capture_prev: assert property (@(posedge clock) disable iff (reset)
      capture |=> prev_count_ff == $past(s1_count_ff))
      else $error("previous count not updated on capture");

   // An item moved out of the input register shows up as a result.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach result register");

   // Backpressure only when both stages are full.
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without full pipeline");
`endif

endmodule
